/* design/ethc_pkg.sv */
`timescale 1ns / 1ps

package ethc_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int COEF_W  = 16;
  localparam int TRANS_W = 32;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;           // x/y working width, Q2.30 plus headroom
  localparam int ZW = 34;           // residual angle width
  localparam int XW = 33;           // sin/cos result width, Q2.30
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;

  // product math
  localparam int PW = 2 * XW;       // Q.60 two-factor product
  localparam int QW = XW + 1;       // rounded Q.30 partial product
  localparam int SW = XW + QW + 2;  // Q.60 sums
  localparam int MATH_LAT = 5;
  localparam int TOTAL_LAT = CORDIC_LAT + MATH_LAT;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [TRANS_W-1:0] trans_x;
    logic signed [TRANS_W-1:0] trans_y;
    logic signed [TRANS_W-1:0] trans_z;
  } in_req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  r00;
    logic signed [COEF_W-1:0]  r01;
    logic signed [COEF_W-1:0]  r02;
    logic signed [COEF_W-1:0]  r10;
    logic signed [COEF_W-1:0]  r11;
    logic signed [COEF_W-1:0]  r12;
    logic signed [COEF_W-1:0]  r20;
    logic signed [COEF_W-1:0]  r21;
    logic signed [COEF_W-1:0]  r22;
    logic signed [TRANS_W-1:0] out_x;
    logic signed [TRANS_W-1:0] out_y;
    logic signed [TRANS_W-1:0] out_z;
  } out_res_t;

  typedef struct packed {
    logic signed [TRANS_W-1:0] x;
    logic signed [TRANS_W-1:0] y;
    logic signed [TRANS_W-1:0] z;
  } trans_t;

  // arctan(2^-i) in units of 2^32 per turn
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return signed'({{(ZW-32){1'b0}}, v});
  endfunction

  // Q.60 to coefficient: round to nearest (ties up), then clamp
  function automatic logic signed [COEF_W-1:0] to_coef(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] half;
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    half = SW'(1) <<< (60 - COEF_W);
    r    = (v + half) >>> (61 - COEF_W);
    hi   = (SW'(1) <<< (COEF_W - 1)) - SW'(1);
    lo   = -(SW'(1) <<< (COEF_W - 1));
    if (r > hi) begin
      return hi[COEF_W-1:0];
    end else if (r < lo) begin
      return lo[COEF_W-1:0];
    end
    return r[COEF_W-1:0];
  endfunction

endpackage

/* design/ethc_cordic.sv */
`timescale 1ns / 1ps

// Fully pipelined rotation-mode CORDIC: one stage register per iteration.
module ethc_cordic (
  input  logic                              clk,
  input  logic [ethc_pkg::ANGLE_W-1:0]      angle,
  output logic signed [ethc_pkg::XW-1:0]    cos_o,
  output logic signed [ethc_pkg::XW-1:0]    sin_o
);

  localparam int N = ethc_pkg::CORDIC_STEPS;

  logic signed [ethc_pkg::CW-1:0] x_r [0:N];
  logic signed [ethc_pkg::CW-1:0] y_r [0:N];
  logic signed [ethc_pkg::ZW-1:0] z_r [0:N];
  logic                           neg_r [0:N];

  logic [31:0]                    ph;
  logic                           neg_nxt;
  logic [31:0]                    phf;
  logic signed [ethc_pkg::CW-1:0] cos_nxt;
  logic signed [ethc_pkg::CW-1:0] sin_nxt;

  // place angle at top of a 32-bit phase, fold quadrants 2 and 3 by pi
  always_comb begin
    ph      = {angle, {(32 - ethc_pkg::ANGLE_W){1'b0}}};
    neg_nxt = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    phf     = neg_nxt ? {~ph[31], ph[30:0]} : ph;
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= ethc_pkg::CORDIC_GAIN;
    y_r[0]   <= '0;
    z_r[0]   <= ethc_pkg::ZW'(signed'(phf));
    neg_r[0] <= neg_nxt;
  end

  // iteration stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [ethc_pkg::CW-1:0] dx;
    logic signed [ethc_pkg::CW-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    // note: dx is the shifted y, dy the shifted x
    always_ff @(posedge clk) begin
      if (!z_r[i][ethc_pkg::ZW-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - ethc_pkg::atan_val(i);
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + ethc_pkg::atan_val(i);
      end
      neg_r[i+1] <= neg_r[i];
    end
  end

  // undo the quadrant fold
  always_comb begin
    cos_nxt = neg_r[N] ? -x_r[N] : x_r[N];
    sin_nxt = neg_r[N] ? -y_r[N] : y_r[N];
  end

  always_ff @(posedge clk) begin
    cos_o <= cos_nxt[ethc_pkg::XW-1:0];
    sin_o <= sin_nxt[ethc_pkg::XW-1:0];
  end

endmodule

/* design/euler_to_homogeneous_transform_core.sv */
`timescale 1ns / 1ps

// Euler Z-Y-X angles to a 3x4 homogeneous transform.
// Request channel: drive in_req and pulse start; a request is taken on
// every rising edge with start high and busy low. busy is always low, so a
// new request may enter on every clock: throughput is one pose per cycle.
// Result channel: out_valid is high for exactly one cycle with the nine
// Q1.15 rotation entries and the translation in out_res. The receiver
// cannot stall, so nothing is held back.
// Pipeline: 37 register stages; out_valid and out_res come from the last
// one together. 32 stages are the three parallel CORDIC pipelines (fold,
// 30 iterations, unfold); 5 are the product pipeline: two-factor
// products, Q.30 rounding, three-factor products, sums, then rounding and
// saturation.
// Reset (rst_n low, synchronous) clears all valid bits; requests in
// flight are dropped and no result appears until new requests arrive.
module euler_to_homogeneous_transform_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ethc_pkg::in_req_t  in_req,
  output logic               out_valid,
  output ethc_pkg::out_res_t out_res
);

  localparam int XW  = ethc_pkg::XW;
  localparam int PW  = ethc_pkg::PW;
  localparam int QW  = ethc_pkg::QW;
  localparam int SW  = ethc_pkg::SW;
  localparam int CL  = ethc_pkg::CORDIC_LAT;
  localparam int TL  = ethc_pkg::TOTAL_LAT;

  localparam logic signed [PW-1:0] HALF30 = PW'(1) <<< 29;

  // no backpressure anywhere in the pipeline
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // valid and translation travel alongside the datapath
  logic               v_r [0:TL-1];
  ethc_pkg::trans_t   t_r [0:TL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TL; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= accept;
      for (int i = 1; i < TL; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r[0] <= '{x: in_req.trans_x, y: in_req.trans_y, z: in_req.trans_z};
    for (int i = 1; i < TL; i++) begin
      t_r[i] <= t_r[i-1];
    end
  end

  // sine and cosine of each angle
  logic signed [XW-1:0] cr, sr, cp, sp, cy, sy;

  ethc_cordic u_roll  (.clk(clk), .angle(in_req.roll_angle),  .cos_o(cr), .sin_o(sr));
  ethc_cordic u_pitch (.clk(clk), .angle(in_req.pitch_angle), .cos_o(cp), .sin_o(sp));
  ethc_cordic u_yaw   (.clk(clk), .angle(in_req.yaw_angle),   .cos_o(cy), .sin_o(sy));

  // M1: products of pairs
  logic signed [PW-1:0] spsr_p_r, spcr_p_r, cycp_r, sycp_r, cpsr_r, cpcr_r;
  logic signed [XW-1:0] m1_cr_r, m1_sr_r, m1_cy_r, m1_sy_r, m1_sp_r;

  always_ff @(posedge clk) begin
    spsr_p_r <= PW'(sp) * PW'(sr);
    spcr_p_r <= PW'(sp) * PW'(cr);
    cycp_r   <= PW'(cy) * PW'(cp);
    sycp_r   <= PW'(sy) * PW'(cp);
    cpsr_r   <= PW'(cp) * PW'(sr);
    cpcr_r   <= PW'(cp) * PW'(cr);
    m1_cr_r  <= cr;
    m1_sr_r  <= sr;
    m1_cy_r  <= cy;
    m1_sy_r  <= sy;
    m1_sp_r  <= sp;
  end

  // M2: round the pitch partial products back to Q.30
  logic signed [QW-1:0] spsr_r, spcr_r;
  logic signed [PW-1:0] spsr_nxt, spcr_nxt;
  logic signed [PW-1:0] m2_cycp_r, m2_sycp_r, m2_cpsr_r, m2_cpcr_r;
  logic signed [XW-1:0] m2_cr_r, m2_sr_r, m2_cy_r, m2_sy_r, m2_sp_r;

  assign spsr_nxt = (spsr_p_r + HALF30) >>> 30;
  assign spcr_nxt = (spcr_p_r + HALF30) >>> 30;

  always_ff @(posedge clk) begin
    spsr_r    <= spsr_nxt[QW-1:0];
    spcr_r    <= spcr_nxt[QW-1:0];
    m2_cycp_r <= cycp_r;
    m2_sycp_r <= sycp_r;
    m2_cpsr_r <= cpsr_r;
    m2_cpcr_r <= cpcr_r;
    m2_cr_r   <= m1_cr_r;
    m2_sr_r   <= m1_sr_r;
    m2_cy_r   <= m1_cy_r;
    m2_sy_r   <= m1_sy_r;
    m2_sp_r   <= m1_sp_r;
  end

  // M3: yaw times the roll/pitch terms
  logic signed [SW-1:0] a01_r, b01_r, a02_r, b02_r, a11_r, b11_r, a12_r, b12_r;
  logic signed [SW-1:0] m3_cycp_r, m3_sycp_r, m3_cpsr_r, m3_cpcr_r;
  logic signed [XW-1:0] m3_sp_r;

  always_ff @(posedge clk) begin
    a01_r     <= SW'(m2_cy_r) * SW'(spsr_r);
    b01_r     <= SW'(m2_sy_r) * SW'(m2_cr_r);
    a02_r     <= SW'(m2_cy_r) * SW'(spcr_r);
    b02_r     <= SW'(m2_sy_r) * SW'(m2_sr_r);
    a11_r     <= SW'(m2_sy_r) * SW'(spsr_r);
    b11_r     <= SW'(m2_cy_r) * SW'(m2_cr_r);
    a12_r     <= SW'(m2_sy_r) * SW'(spcr_r);
    b12_r     <= SW'(m2_cy_r) * SW'(m2_sr_r);
    m3_cycp_r <= SW'(m2_cycp_r);
    m3_sycp_r <= SW'(m2_sycp_r);
    m3_cpsr_r <= SW'(m2_cpsr_r);
    m3_cpcr_r <= SW'(m2_cpcr_r);
    m3_sp_r   <= m2_sp_r;
  end

  // M4: sums in Q.60
  logic signed [SW-1:0] s00_r, s01_r, s02_r, s10_r, s11_r, s12_r, s20_r, s21_r, s22_r;

  always_ff @(posedge clk) begin
    s00_r <= m3_cycp_r;
    s01_r <= a01_r - b01_r;
    s02_r <= a02_r + b02_r;
    s10_r <= m3_sycp_r;
    s11_r <= a11_r + b11_r;
    s12_r <= a12_r - b12_r;
    s20_r <= -(SW'(m3_sp_r) <<< 30);
    s21_r <= m3_cpsr_r;
    s22_r <= m3_cpcr_r;
  end

  // M5: round, saturate, register the result
  ethc_pkg::trans_t t_out;
  assign t_out = t_r[TL-2];

  always_ff @(posedge clk) begin
    out_res.r00   <= ethc_pkg::to_coef(s00_r);
    out_res.r01   <= ethc_pkg::to_coef(s01_r);
    out_res.r02   <= ethc_pkg::to_coef(s02_r);
    out_res.r10   <= ethc_pkg::to_coef(s10_r);
    out_res.r11   <= ethc_pkg::to_coef(s11_r);
    out_res.r12   <= ethc_pkg::to_coef(s12_r);
    out_res.r20   <= ethc_pkg::to_coef(s20_r);
    out_res.r21   <= ethc_pkg::to_coef(s21_r);
    out_res.r22   <= ethc_pkg::to_coef(s22_r);
    out_res.out_x <= t_out.x;
    out_res.out_y <= t_out.y;
    out_res.out_z <= t_out.z;
  end

  assign out_valid = v_r[TL-1];

  // every accepted request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(TL) out_valid)
    else $error("result missing after pipeline latency");

  // a result only follows a request accepted at the fixed latency
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v_r[CL-1], TL - CL))
    else $error("result without matching request");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

/* tb/euler_to_homogeneous_transform_core_tb.sv */
`timescale 1ns / 1ps

module euler_to_homogeneous_transform_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam int IN_W = $bits(ethc_pkg::in_req_t);

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ethc_pkg::in_req_t  in_req;
  logic               out_valid;
  ethc_pkg::out_res_t out_res;

  ethc_pkg::out_res_t pose_expect_q[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       send_idle_pct;

  euler_to_homogeneous_transform_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // floor shift on 64-bit signed values
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine of a binary angle, Q2.30
  task automatic angle_sincos(input logic [ethc_pkg::ANGLE_W-1:0] ang,
                              output longint c, output longint s);
    logic [31:0] ph;
    logic        flip;
    longint      x, y, z, dx, dy;
    ph   = {ang, {(32 - ethc_pkg::ANGLE_W){1'b0}}};
    flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (flip) ph = ph + 32'h8000_0000;
    x = longint'(GAIN_Q30);
    y = 0;
    z = longint'(signed'(ph));
    for (int i = 0; i < ethc_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ethc_pkg::atan_val(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ethc_pkg::atan_val(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [ethc_pkg::COEF_W-1:0] q60_to_coef(input longint v);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ethc_pkg::COEF_W - 1)) - 1;
    lo = -(longint'(1) <<< (ethc_pkg::COEF_W - 1));
    r  = round_shr(v, 60 - (ethc_pkg::COEF_W - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[ethc_pkg::COEF_W-1:0];
  endfunction

  // expected transform for one pose
  task automatic predict_transform(input ethc_pkg::in_req_t req,
                                   output ethc_pkg::out_res_t res);
    longint cr, sr, cp, sp, cy, sy, spsr, spcr;
    angle_sincos(req.roll_angle, cr, sr);
    angle_sincos(req.pitch_angle, cp, sp);
    angle_sincos(req.yaw_angle, cy, sy);
    spsr = round_shr(sp * sr, 30);
    spcr = round_shr(sp * cr, 30);
    res.r00 = q60_to_coef(cy * cp);
    res.r01 = q60_to_coef(cy * spsr - sy * cr);
    res.r02 = q60_to_coef(cy * spcr + sy * sr);
    res.r10 = q60_to_coef(sy * cp);
    res.r11 = q60_to_coef(sy * spsr + cy * cr);
    res.r12 = q60_to_coef(sy * spcr - cy * sr);
    res.r20 = q60_to_coef(-sp * (longint'(1) <<< 30));
    res.r21 = q60_to_coef(cp * sr);
    res.r22 = q60_to_coef(cp * cr);
    res.out_x = req.trans_x;
    res.out_y = req.trans_y;
    res.out_z = req.trans_z;
  endtask

  function automatic ethc_pkg::in_req_t rand_pose();
    ethc_pkg::in_req_t r;
    r = ethc_pkg::in_req_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom}));
    return r;
  endfunction

  // drive one request at the current edge, with random idle cycles before it;
  // returns at the edge that takes it, start still high
  task automatic send_pose(input ethc_pkg::in_req_t req);
    ethc_pkg::out_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      start  <= 1'b0;
      in_req <= rand_pose();
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    predict_transform(req, res);
    pose_expect_q = {pose_expect_q, res};
    do @(posedge clk); while (busy);
  endtask

  function automatic ethc_pkg::in_req_t make_pose(input logic [15:0] ro,
                                                  input logic [15:0] pi,
                                                  input logic [15:0] ya);
    ethc_pkg::in_req_t r;
    r = rand_pose();
    r.roll_angle = ro;
    r.pitch_angle = pi;
    r.yaw_angle = ya;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    ethc_pkg::out_res_t exp_r;
    if (rst_n && out_valid) begin
      if (pose_expect_q.size() == 0) begin
        $error("unexpected result %h", out_res);
        error_count++;
      end else begin
        exp_r = pose_expect_q.pop_front();
        if (out_res.r00 !== exp_r.r00) begin
          $error("r00 exp %h got %h", exp_r.r00, out_res.r00); error_count++;
        end
        if (out_res.r01 !== exp_r.r01) begin
          $error("r01 exp %h got %h", exp_r.r01, out_res.r01); error_count++;
        end
        if (out_res.r02 !== exp_r.r02) begin
          $error("r02 exp %h got %h", exp_r.r02, out_res.r02); error_count++;
        end
        if (out_res.r10 !== exp_r.r10) begin
          $error("r10 exp %h got %h", exp_r.r10, out_res.r10); error_count++;
        end
        if (out_res.r11 !== exp_r.r11) begin
          $error("r11 exp %h got %h", exp_r.r11, out_res.r11); error_count++;
        end
        if (out_res.r12 !== exp_r.r12) begin
          $error("r12 exp %h got %h", exp_r.r12, out_res.r12); error_count++;
        end
        if (out_res.r20 !== exp_r.r20) begin
          $error("r20 exp %h got %h", exp_r.r20, out_res.r20); error_count++;
        end
        if (out_res.r21 !== exp_r.r21) begin
          $error("r21 exp %h got %h", exp_r.r21, out_res.r21); error_count++;
        end
        if (out_res.r22 !== exp_r.r22) begin
          $error("r22 exp %h got %h", exp_r.r22, out_res.r22); error_count++;
        end
        if (out_res.out_x !== exp_r.out_x) begin
          $error("out_x exp %h got %h", exp_r.out_x, out_res.out_x); error_count++;
        end
        if (out_res.out_y !== exp_r.out_y) begin
          $error("out_y exp %h got %h", exp_r.out_y, out_res.out_y); error_count++;
        end
        if (out_res.out_z !== exp_r.out_z) begin
          $error("out_z exp %h got %h", exp_r.out_z, out_res.out_z); error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // drop start and wait until every expected result has come
  task automatic wait_results_done();
    start <= 1'b0;
    do @(posedge clk); while (pose_expect_q.size() != 0);
  endtask

  // extremes of angles and translations, quadrant edges, minus pi
  task automatic test_directed();
    logic [15:0] corner[8];
    ethc_pkg::in_req_t r;
    corner = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h3FFF,
               16'h0001, 16'hFFFF};
    send_idle_pct = 0;
    for (int i = 0; i < 8; i++) begin
      send_pose(make_pose(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]));
    end
    for (int i = 0; i < 8; i++) begin
      send_pose(make_pose(corner[i], corner[i], corner[i]));
    end
    r = make_pose(16'h8000, 16'h4000, 16'h8000);
    r.trans_x = 32'h8000_0000; r.trans_y = 32'h7FFF_FFFF; r.trans_z = 32'h0;
    send_pose(r);
    r = make_pose(16'h2000, 16'hC000, 16'hE000);
    r.trans_x = 32'h7FFF_FFFF; r.trans_y = 32'h8000_0000; r.trans_z = 32'hFFFF_FFFF;
    send_pose(r);
    wait_results_done();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_pose(rand_pose());
      // hold off until the pipeline has drained
      if (i == count / 2) wait_results_done();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    send_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(700, 0);
    test_random(400, 88);
    test_random(400, 0);
    test_random(450, 35);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ethc_pkg.sv
design/ethc_cordic.sv
design/euler_to_homogeneous_transform_core.sv
tb/euler_to_homogeneous_transform_core_tb.sv
